[rtl/core/tcc_pkg.sv]
`default_nettype none

package tcc_pkg;

    // default geometry
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // field widths of the stream payloads
    localparam int CELL_W      = 16;
    localparam int IDX_W       = 11;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // character and attribute constants
    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] RESET_COLOR = 8'h07;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_SETCUR = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // sequencer states
    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_EXEC,
        ST_RUN,
        ST_EMIT,
        ST_RDWAIT,
        ST_COPY
    } t_state;

endpackage

`default_nettype wire

[rtl/core/tcc_ram.sv]
`default_nettype none

module tcc_ram
    import tcc_pkg::*;
#(
    parameter int WIDTH = CELL_W,
    parameter int DEPTH = COLUMNS_DEF * ROWS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/tcc_index_unit.sv]
`default_nettype none

module tcc_index_unit
    import tcc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic [$clog2(ROWS)-1:0]           i_row,
    input  wire logic [$clog2(COLUMNS)-1:0]        i_col,
    output logic      [$clog2(COLUMNS*ROWS)-1:0]   o_index
);

    localparam int AW = $clog2(COLUMNS * ROWS);

    // linear cell address: row times line length plus column
    assign o_index = AW'(i_row) * AW'(COLUMNS) + AW'(i_col);

endmodule

`default_nettype wire

[rtl/core/text_console_cursor_engine.sv]
`default_nettype none
// channel | direction | handshake                   | payload
// s_axis  | in        | s_axis_tvalid/s_axis_tready | tdata char_code, pos_x, pos_y; tuser req_type
// m_axis  | out       | m_axis_tvalid/m_axis_tready | tdata index, value, scrolled, col, row;
//         |           |                             | tuser flags
// cfg     | in        | i_cfg_wr_en                 | i_cfg_wr_data text_color
//
// a request gives one or more results (a tab gives up to TAB_STOP results)
// a scroll runs a row copy that walks the cell store one cell a cycle, then blanks the last row
// a clear fills the store with blanks through the single store write port
// after reset a fill pass blanks the store before the first request
// a result waits in the output register while the next request is taken in

module text_console_cursor_engine
    import tcc_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [7:0]             i_cfg_wr_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] char_code, [15:8] pos_x, [23:16] pos_y
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [10:0] cell_index, [26:11] cell_value, [27] scrolled, [34:28] cursor_col,
    // [39:35] cursor_row
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] cell_written, [1] read_ok
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(TAB_STOP);
    localparam int NW    = PW + 1;
    localparam int MW    = (CW + 1 > NW) ? CW + 1 : NW;

    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [PW-1:0] LAST_PHASE = PW'((COLUMNS - 1) % TAB_STOP);
    localparam logic [PW-1:0] TS_M1      = PW'(TAB_STOP - 1);
    localparam logic [AW-1:0] CELLS_M1   = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END   = AW'(CELLS - COLUMNS);

    // sequencer and cursor state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [PW-1:0]       r_phase, n_phase;
    logic [7:0]          r_color;
    logic                r_scr, n_scr;
    logic                r_clr, n_clr;

    // latched request
    t_req                r_req;
    logic [7:0]          r_ch;
    logic [7:0]          r_px;
    logic [7:0]          r_py;
    logic [7:0]          r_icolor;

    // cell run, single result and store walk
    logic [AW-1:0]       r_run_idx, n_run_idx;
    logic [NW-1:0]       r_run_cnt, n_run_cnt;
    logic [CELL_W-1:0]   r_run_val, n_run_val;
    logic [CELL_W-1:0]   r_emit_val, n_emit_val;
    logic [AW-1:0]       r_walk, n_walk;
    logic [CELL_W-1:0]   r_fill_val, n_fill_val;
    logic                r_cp_vld, n_cp_vld;
    logic [AW-1:0]       r_cp_dst, n_cp_dst;

    // output register
    logic                r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic [OUT_TUSER_W-1:0] r_m_user;
    logic                r_m_last;

    // combinational helpers
    logic                w_in_acc;
    logic                w_slot_free;
    logic                w_x_ok, w_y_ok;
    logic                w_is_tab, w_is_bs;
    logic [CW-1:0]       w_bs_col;
    logic [RW-1:0]       w_bs_row;
    logic [PW-1:0]       w_bs_phase;
    logic [RW-1:0]       w_idx_row;
    logic [CW-1:0]       w_idx_col;
    logic [AW-1:0]       w_idx;
    logic [MW-1:0]       w_rem_line, w_rem_tab, w_run_n, w_ph_sum;
    logic                w_wrap;
    logic [CW-1:0]       w_adv_col;
    logic [PW-1:0]       w_adv_phase;
    logic [PW-1:0]       w_phase_lut [2**CW];

    // store port and result controls
    logic                w_ram_wr_en;
    logic [AW-1:0]       w_ram_wr_addr;
    logic [CELL_W-1:0]   w_ram_wr_data;
    logic                w_ram_rd_en;
    logic [AW-1:0]       w_ram_rd_addr;
    logic [CELL_W-1:0]   w_ram_rd_data;
    logic                w_out_load;
    logic                w_o_written;
    logic                w_o_rok;
    logic                w_o_last;
    logic [AW-1:0]       w_o_idx;
    logic [CELL_W-1:0]   w_o_val;
    logic                w_emit_done;

    // column to tab phase table
    for (genvar g = 0; g < 2**CW; g++) begin : g_phase_lut
        assign w_phase_lut[g] = PW'(g % TAB_STOP);
    end

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_m_valid || m_axis_tready;

    // request decode helpers
    assign w_x_ok   = !r_px[7] && (r_px < 8'(COLUMNS));
    assign w_y_ok   = !r_py[7] && (r_py < 8'(ROWS));
    assign w_is_tab = (r_ch == CH_TAB);
    assign w_is_bs  = (r_ch == CH_BS);

    // backspace position, wrapping to the previous row
    always_comb begin
        w_bs_col   = r_col;
        w_bs_row   = r_row;
        w_bs_phase = r_phase;
        if (r_col != '0) begin
            w_bs_col   = r_col - 1'b1;
            w_bs_phase = (r_phase == '0) ? TS_M1 : r_phase - 1'b1;
        end else if (r_row != '0) begin
            w_bs_row   = r_row - 1'b1;
            w_bs_col   = LAST_COL;
            w_bs_phase = LAST_PHASE;
        end
    end

    // operand select for the shared index unit
    always_comb begin
        w_idx_row = r_row;
        w_idx_col = r_col;
        if (r_req == REQ_READ) begin
            w_idx_row = r_py[RW-1:0];
            w_idx_col = r_px[CW-1:0];
        end else if (r_req == REQ_PUT && w_is_bs) begin
            w_idx_row = w_bs_row;
            w_idx_col = w_bs_col;
        end
    end

    tcc_index_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_index (
        .i_row   (w_idx_row),
        .i_col   (w_idx_col),
        .o_index (w_idx)
    );

    // length of a cell run and where the cursor lands after it
    assign w_rem_line  = MW'(COLUMNS) - MW'(r_col);
    assign w_rem_tab   = MW'(TAB_STOP) - MW'(r_phase);
    assign w_run_n     = w_is_tab ? ((w_rem_line <= w_rem_tab) ? w_rem_line : w_rem_tab)
                                  : MW'(1);
    assign w_wrap      = (w_run_n == w_rem_line);
    assign w_adv_col   = r_col + CW'(w_run_n);
    assign w_ph_sum    = MW'(r_phase) + w_run_n;
    assign w_adv_phase = (w_ph_sum == MW'(TAB_STOP)) ? '0 : PW'(w_ph_sum);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (r_walk == CELLS_M1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_req)
                    REQ_PUT: begin
                        if (r_ch == CH_NL || r_ch == CH_CR) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_RUN;
                        end
                    end
                    REQ_READ: begin
                        n_state = (w_x_ok && w_y_ok) ? ST_RDWAIT : ST_EMIT;
                    end
                    REQ_SETCUR, REQ_CLEAR: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_RUN, ST_EMIT, ST_RDWAIT: begin
                if (w_emit_done) begin
                    if (r_scr) begin
                        n_state = ST_COPY;
                    end else if (r_clr) begin
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_COPY: begin
                if (r_walk == COPY_END) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: store port, result fields, input ready
    always_comb begin
        s_axis_tready = 1'b0;
        w_ram_wr_en   = 1'b0;
        w_ram_wr_addr = r_walk;
        w_ram_wr_data = r_fill_val;
        w_ram_rd_en   = 1'b0;
        w_ram_rd_addr = w_idx;
        w_out_load    = 1'b0;
        w_o_written   = 1'b0;
        w_o_rok       = 1'b0;
        w_o_last      = 1'b1;
        w_o_idx       = '0;
        w_o_val       = r_emit_val;
        unique case (r_state)
            ST_FILL: begin
                w_ram_wr_en = 1'b1;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_EXEC: begin
                w_ram_rd_en = (r_req == REQ_READ) && w_x_ok && w_y_ok;
            end
            ST_RUN: begin
                w_out_load    = w_slot_free;
                w_ram_wr_en   = w_slot_free;
                w_ram_wr_addr = r_run_idx;
                w_ram_wr_data = r_run_val;
                w_o_written   = 1'b1;
                w_o_last      = (r_run_cnt == NW'(1));
                w_o_idx       = r_run_idx;
                w_o_val       = r_run_val;
            end
            ST_EMIT: begin
                w_out_load = w_slot_free;
            end
            ST_RDWAIT: begin
                w_out_load = w_slot_free;
                w_o_rok    = 1'b1;
                w_o_idx    = r_run_idx;
                w_o_val    = w_ram_rd_data;
            end
            ST_COPY: begin
                w_ram_wr_en   = r_cp_vld;
                w_ram_wr_addr = r_cp_dst;
                w_ram_wr_data = w_ram_rd_data;
                w_ram_rd_en   = (r_walk != COPY_END);
                w_ram_rd_addr = r_walk + AW'(COLUMNS);
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign w_emit_done = w_out_load && w_o_last;

    // cursor update and post actions, settled in the execute cycle
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_phase = r_phase;
        n_scr   = r_scr;
        n_clr   = r_clr;
        if (r_state == ST_EXEC) begin
            n_scr = 1'b0;
            n_clr = 1'b0;
            unique case (r_req)
                REQ_PUT: begin
                    if (r_ch == CH_NL) begin
                        n_col   = '0;
                        n_phase = '0;
                        if (r_row == LAST_ROW) begin
                            n_scr = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else if (r_ch == CH_CR) begin
                        n_col   = '0;
                        n_phase = '0;
                    end else if (w_is_bs) begin
                        n_col   = w_bs_col;
                        n_row   = w_bs_row;
                        n_phase = w_bs_phase;
                    end else if (w_wrap) begin
                        n_col   = '0;
                        n_phase = '0;
                        if (r_row == LAST_ROW) begin
                            n_scr = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col   = w_adv_col;
                        n_phase = w_adv_phase;
                    end
                end
                REQ_SETCUR: begin
                    if (w_x_ok) begin
                        n_col   = r_px[CW-1:0];
                        n_phase = w_phase_lut[r_px[CW-1:0]];
                    end
                    if (w_y_ok) begin
                        n_row = r_py[RW-1:0];
                    end
                end
                REQ_READ: begin
                    n_col = r_col;
                end
                REQ_CLEAR: begin
                    n_col   = '0;
                    n_row   = '0;
                    n_phase = '0;
                    n_clr   = 1'b1;
                end
            endcase
        end
    end

    // run, single result and store walk datapath
    always_comb begin
        n_run_idx  = r_run_idx;
        n_run_cnt  = r_run_cnt;
        n_run_val  = r_run_val;
        n_emit_val = r_emit_val;
        n_walk     = r_walk;
        n_fill_val = r_fill_val;
        n_cp_vld   = r_cp_vld;
        n_cp_dst   = r_cp_dst;
        case (r_state)
            ST_EXEC: begin
                n_run_idx  = w_idx;
                n_run_cnt  = NW'(w_run_n);
                n_run_val  = {r_icolor, (w_is_tab || w_is_bs) ? BLANK_CHAR : r_ch};
                n_emit_val = (r_req == REQ_CLEAR) ? {r_icolor, BLANK_CHAR} : '0;
            end
            ST_RUN: begin
                if (w_slot_free) begin
                    n_run_idx = r_run_idx + 1'b1;
                    n_run_cnt = r_run_cnt - 1'b1;
                end
            end
            ST_FILL: begin
                n_walk = r_walk + 1'b1;
            end
            ST_COPY: begin
                if (r_walk == COPY_END) begin
                    n_cp_vld   = 1'b0;
                    n_fill_val = {r_icolor, BLANK_CHAR};
                end else begin
                    n_cp_vld = 1'b1;
                    n_cp_dst = r_walk;
                    n_walk   = r_walk + 1'b1;
                end
            end
            default: n_walk = r_walk;
        endcase
        // start of a scroll copy or a clear fill
        if (w_emit_done) begin
            n_walk     = '0;
            n_cp_vld   = 1'b0;
            n_fill_val = {r_icolor, BLANK_CHAR};
        end
    end

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (w_ram_rd_addr),
        .o_rd_data (w_ram_rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_col      <= '0;
            r_row      <= '0;
            r_phase    <= '0;
            r_color    <= RESET_COLOR;
            r_scr      <= 1'b0;
            r_clr      <= 1'b0;
            r_run_cnt  <= '0;
            r_walk     <= '0;
            r_fill_val <= {RESET_COLOR, BLANK_CHAR};
            r_cp_vld   <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_phase    <= n_phase;
            r_scr      <= n_scr;
            r_clr      <= n_clr;
            r_run_cnt  <= n_run_cnt;
            r_walk     <= n_walk;
            r_fill_val <= n_fill_val;
            r_cp_vld   <= n_cp_vld;
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req    <= t_req'(s_axis_tuser[1:0]);
            r_ch     <= s_axis_tdata[7:0];
            r_px     <= s_axis_tdata[15:8];
            r_py     <= s_axis_tdata[23:16];
            r_icolor <= r_color;
        end
        r_run_idx  <= n_run_idx;
        r_run_val  <= n_run_val;
        r_emit_val <= n_emit_val;
        r_cp_dst   <= n_cp_dst;
        if (w_out_load) begin
            r_m_data <= {ROW_W'(r_row), COL_W'(r_col), r_scr, w_o_val, IDX_W'(w_o_idx)};
            r_m_user <= {w_o_rok, w_o_written};
            r_m_last <= w_o_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= LAST_COL) && (r_row <= LAST_ROW) && (r_phase <= TS_M1))
        else $error("cursor or tab phase out of range");

    // a cell run always has a cell left to write
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_run_cnt != '0))
        else $error("cell run entered with zero length");

    // store writes stay inside the cell store
    a_wr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_wr_en |-> (w_ram_wr_addr <= CELLS_M1))
        else $error("store write beyond last cell");

    // execute always follows a taken request
    a_exec_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_EXEC))
        else $error("taken request not executed");

    // a copied cell is written one row above where it was read
    a_copy_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && r_cp_vld) |-> (r_cp_dst + AW'(COLUMNS) == $past(w_ram_rd_addr)))
        else $error("scroll copy destination mismatch");

endmodule

`default_nettype wire
